### rtl/core/bls_pkg.sv
package bls_pkg;

  // default configuration of the block
  localparam int unsigned Window     = 20;
  localparam int unsigned SampleBits = 16;

  // fixed field widths
  localparam int unsigned FieldW  = 16;
  localparam int unsigned CfgIdxW = 1;

  // register reset values
  localparam logic [FieldW-1:0] LowThrReset  = 16'h9700;
  localparam logic [FieldW-1:0] HighThrReset = 16'hA1BC;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgLowThr  = 1'b0,
    CfgHighThr = 1'b1
  } cfg_idx_e;

  // action codes reported with each result
  typedef enum logic [1:0] {
    ActNone     = 2'd0,
    ActLowPower = 2'd1,
    ActSysReset = 2'd2
  } action_e;

  // status carried from the window stage to the output stage
  typedef struct packed {
    logic    warm;
    logic    low_power;
    action_e action;
  } status_t;

endpackage

### rtl/core/battery_level_supervisor.sv
// channel   direction  handshake                  payload
// cfg       in         cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
// sample    in         in_valid_i / in_ready_o    sample_i
// result    out        out_valid_o / out_ready_i  average_o, average_valid_o,
//                                                 low_power_o, action_o
//
// one sample per cycle while the output is not stalled; each result is registered in
// the window/sum update stage, then by reciprocal multiply into the output register
// reset: window, sum, warm-up and mode cleared, thresholds reloaded, at once, no sweep
// a stalled output holds both stages; sample input stays ready while any stage is free
module battery_level_supervisor #(
  parameter int unsigned WINDOW      = bls_pkg::Window,
  parameter int unsigned SAMPLE_BITS = bls_pkg::SampleBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bls_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bls_pkg::FieldW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bls_pkg::FieldW-1:0]   sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bls_pkg::FieldW-1:0]   average_o,
  output logic                         average_valid_o,
  output logic                         low_power_o,
  output logic [1:0]                   action_o
);

  localparam int unsigned SUM_W = $clog2(WINDOW * ((2 ** SAMPLE_BITS) - 1) + 1);

  logic             mid_valid;
  logic             mid_ready;
  logic [SUM_W-1:0] mid_sum;
  bls_pkg::status_t mid_status;
  bls_pkg::status_t res_status;

  // window and running sum stage
  bls_window #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i[SAMPLE_BITS-1:0]),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .sum_o       (mid_sum),
    .status_o    (mid_status)
  );

  // average and output register
  bls_divide #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .sum_i       (mid_sum),
    .status_i    (mid_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .average_o   (average_o),
    .status_o    (res_status)
  );

  assign average_valid_o = res_status.warm;
  assign low_power_o     = res_status.low_power;
  assign action_o        = res_status.action;

endmodule

### rtl/core/bls_window.sv
module bls_window #(
  parameter int unsigned WINDOW      = bls_pkg::Window,
  parameter int unsigned SAMPLE_BITS = bls_pkg::SampleBits,
  parameter int unsigned SUM_W       = 21
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bls_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bls_pkg::FieldW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [SUM_W-1:0]             sum_o,
  output bls_pkg::status_t             status_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);

  logic [SAMPLE_BITS-1:0]     win_q [WINDOW];
  logic [SUM_W-1:0]           sum_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       warm_q;
  logic                       mode_q;
  logic [bls_pkg::FieldW-1:0] low_thr_q;
  logic [bls_pkg::FieldW-1:0] high_thr_q;
  logic                       valid_q;
  logic [SUM_W-1:0]           res_sum_q;
  bls_pkg::status_t           res_status_q;

  logic [bls_pkg::FieldW-1:0] samp_ext;
  logic                       accept;
  logic                       enter_lp;
  logic                       sys_rst;
  logic [SUM_W-1:0]           sum_d;
  logic                       warm_d;
  logic                       mode_d;

  // the stage takes a transfer whenever its result slot frees up
  assign in_ready_o = ~valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  // threshold checks, only once the window is warm
  always_comb begin
    samp_ext = bls_pkg::FieldW'(sample_i);
    enter_lp = warm_q & (samp_ext < low_thr_q) & ~mode_q;
    sys_rst  = warm_q & (samp_ext > high_thr_q) & (mode_q | enter_lp);
    sum_d    = sum_q - SUM_W'(win_q[WINDOW-1]) + SUM_W'(sample_i);
    warm_d   = warm_q | (cnt_q == CNT_W'(WINDOW));
    mode_d   = mode_q | enter_lp;
  end

  // window, running sum, mode and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      warm_q     <= 1'b0;
      mode_q     <= 1'b0;
      low_thr_q  <= bls_pkg::LowThrReset;
      high_thr_q <= bls_pkg::HighThrReset;
    end else if (accept && sys_rst) begin
      // system reset request returns everything to reset values
      for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      warm_q     <= 1'b0;
      mode_q     <= 1'b0;
      low_thr_q  <= bls_pkg::LowThrReset;
      high_thr_q <= bls_pkg::HighThrReset;
    end else begin
      if (accept) begin
        win_q[0] <= sample_i;
        for (int i = 1; i < WINDOW; i++) win_q[i] <= win_q[i-1];
        sum_q  <= sum_d;
        warm_q <= warm_d;
        mode_q <= mode_d;
        if (!warm_q && (cnt_q != CNT_W'(WINDOW))) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (cfg_we_i) begin
        unique case (bls_pkg::cfg_idx_e'(cfg_idx_i))
          bls_pkg::CfgLowThr:  low_thr_q  <= cfg_data_i;
          bls_pkg::CfgHighThr: high_thr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // result slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // result slot payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (sys_rst) begin
        res_sum_q              <= '0;
        res_status_q.warm      <= 1'b0;
        res_status_q.low_power <= 1'b0;
        res_status_q.action    <= bls_pkg::ActSysReset;
      end else begin
        res_sum_q              <= sum_d;
        res_status_q.warm      <= warm_d;
        res_status_q.low_power <= mode_d;
        res_status_q.action    <= enter_lp ? bls_pkg::ActLowPower : bls_pkg::ActNone;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign sum_o       = res_sum_q;
  assign status_o    = res_status_q;

endmodule

### rtl/core/bls_divide.sv
module bls_divide #(
  parameter int unsigned WINDOW = bls_pkg::Window,
  parameter int unsigned SUM_W  = 21
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [SUM_W-1:0]           sum_i,
  input  bls_pkg::status_t           status_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bls_pkg::FieldW-1:0] average_o,
  output bls_pkg::status_t           status_o
);

  // exact reciprocal: m = ceil(2^(SUM_W+L) / WINDOW), L = ceil(log2 WINDOW)
  localparam int unsigned SHIFT_L = $clog2(WINDOW);
  localparam int unsigned TOT_SH  = SUM_W + SHIFT_L;
  localparam int unsigned M_W     = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + M_W;
  localparam int unsigned Q_W     = PROD_W - TOT_SH;
  localparam longint unsigned RecipM =
    ((64'd1 << TOT_SH) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);

  logic [M_W-1:0]             recip;
  logic [PROD_W-1:0]          prod;
  logic [Q_W-1:0]             quot;
  logic                       valid_q;
  logic [bls_pkg::FieldW-1:0] avg_q;
  bls_pkg::status_t           status_q;

  assign in_ready_o = ~valid_q | out_ready_i;

  // floor(sum / WINDOW) by reciprocal multiply, no correction needed
  always_comb begin
    recip = M_W'(RecipM);
    prod  = PROD_W'(sum_i) * PROD_W'(recip);
    quot  = prod[PROD_W-1:TOT_SH];
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      avg_q    <= bls_pkg::FieldW'(quot);
      status_q <= status_i;
    end
  end

  assign out_valid_o = valid_q;
  assign average_o   = avg_q;
  assign status_o    = status_q;

endmodule
